// ----- rtl/core/scq_pkg.sv -----
package scq_pkg;

    localparam int NOTE_W        = 7;
    localparam int STEP_W        = 4;
    localparam int COUNT_W       = 4;
    localparam int TABLE_ENTRIES = 12;
    localparam int TABLE_W       = TABLE_ENTRIES * STEP_W;
    localparam int SEMITONES     = 12;
    localparam int CAND_W        = 9;
    localparam int DIFF_W        = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = TABLE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NOTE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_TABLE = 2'd2;

    typedef struct packed {
        logic start;
        logic step;
        logic load_out;
    } scq_cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_last;
    } scq_stat_t;

endpackage

// ----- rtl/core/scale_note_quantizer.sv -----
// Snaps a note to the nearest note of a scale built as root plus twelve per octave plus
// one of up to twelve interval offsets, over OCTAVE_COUNT octaves, keeping notes 0 to 127.
// Ties go to the higher note; a winning root after a root returns the previous winner.
// An item's scan covers OCTAVE_COUNT octaves of the active interval count (at most
// MAX_INTERVALS and twelve), and is skipped when that count is zero: the scan
// tests one candidate per cycle in a single compare unit, and one item is in work at a time.
// The finished result sits in an output register, so the next item is accepted while it
// waits to be taken.
// Configuration: index 0 root note, 1 interval count, 2 packed interval table.
module scale_note_quantizer #(
    parameter int MAX_INTERVALS = 12,
    parameter int OCTAVE_COUNT  = 11
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [scq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [scq_pkg::NOTE_W-1:0]        s_input_note,
    input  logic [scq_pkg::NOTE_W-1:0]        s_prior_note,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [scq_pkg::NOTE_W-1:0]        m_quantized_note,
    output logic                              m_fell_back
);
    import scq_pkg::*;

    logic [NOTE_W-1:0]  root_note_reg;
    logic [COUNT_W-1:0] interval_count_reg;
    logic [TABLE_W-1:0] interval_table_reg;
    scq_cmd_t           cmd;
    scq_stat_t          stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_note_reg      <= '0;
            interval_count_reg <= COUNT_W'(7);
            interval_table_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROOT_NOTE:      root_note_reg      <= cfg_wdata[NOTE_W-1:0];
                CFG_INTERVAL_COUNT: interval_count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_INTERVAL_TABLE: interval_table_reg <= cfg_wdata[TABLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    scq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    scq_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .OCTAVE_COUNT  (OCTAVE_COUNT)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .root_note        (root_note_reg),
        .interval_count   (interval_count_reg),
        .interval_table   (interval_table_reg),
        .s_input_note     (s_input_note),
        .s_prior_note     (s_prior_note),
        .m_quantized_note (m_quantized_note),
        .m_fell_back      (m_fell_back)
    );

endmodule

// ----- rtl/core/scq_ctrl.sv -----
module scq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  scq_pkg::scq_stat_t stat,
    output scq_pkg::scq_cmd_t  cmd
);
    import scq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.empty) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.step = 1'b1;
                    if (stat.scan_last) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/core/scq_datapath.sv -----
module scq_datapath #(
    parameter int MAX_INTERVALS = 12,
    parameter int OCTAVE_COUNT  = 11
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  scq_pkg::scq_cmd_t                  cmd,
    output scq_pkg::scq_stat_t                 stat,
    input  logic [scq_pkg::NOTE_W-1:0]         root_note,
    input  logic [scq_pkg::COUNT_W-1:0]        interval_count,
    input  logic [scq_pkg::TABLE_W-1:0]        interval_table,
    input  logic [scq_pkg::NOTE_W-1:0]         s_input_note,
    input  logic [scq_pkg::NOTE_W-1:0]         s_prior_note,
    output logic [scq_pkg::NOTE_W-1:0]         m_quantized_note,
    output logic                               m_fell_back
);
    import scq_pkg::*;

    localparam int LIM   = (MAX_INTERVALS < TABLE_ENTRIES) ? MAX_INTERVALS : TABLE_ENTRIES;
    localparam int OCT_W = (OCTAVE_COUNT > 1) ? $clog2(OCTAVE_COUNT) : 1;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [COUNT_W-1:0] LIM_C    = COUNT_W'(LIM);
    localparam logic [OCT_W-1:0]   OCT_LAST = OCT_W'(OCTAVE_COUNT - 1);

    logic [STEP_W-1:0]  steps [TABLE_ENTRIES];
    logic [COUNT_W-1:0] count_eff;
    logic               idx_last;

    logic [NOTE_W-1:0]  note_reg;
    logic [NOTE_W-1:0]  prior_reg;
    logic [OCT_W-1:0]   oct_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CAND_W-1:0]  base_reg;
    logic               have_best_reg;
    logic [NOTE_W-1:0]  best_reg;
    logic [DIFF_W-1:0]  best_diff_reg;
    logic               have_second_reg;
    logic [NOTE_W-1:0]  second_reg;
    logic [NOTE_W-1:0]  q_reg;
    logic               fb_reg;

    logic [CAND_W-1:0]  cand;
    logic [NOTE_W-1:0]  cand_note;
    logic               cand_ok;
    logic [DIFF_W-1:0]  diff;
    logic               take;
    logic               swap_root;
    logic [NOTE_W-1:0]  result;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_steps
        assign steps[g] = interval_table[g*STEP_W +: STEP_W];
    end

    assign count_eff = (interval_count > LIM_C) ? LIM_C : interval_count;
    assign idx_last  = ({1'b0, idx_reg} == ({1'b0, count_eff} - (COUNT_W+1)'(1)));

    assign stat.empty     = (count_eff == '0);
    assign stat.scan_last = idx_last && (oct_reg == OCT_LAST);

    assign cand      = base_reg + CAND_W'(steps[idx_reg]);
    assign cand_note = cand[NOTE_W-1:0];
    assign cand_ok   = (cand[CAND_W-1:NOTE_W] == '0);
    assign diff      = (cand_note > note_reg) ? DIFF_W'(cand_note - note_reg)
                                              : DIFF_W'(note_reg - cand_note);
    assign take      = cand_ok && ((diff < best_diff_reg) ||
                       (diff == best_diff_reg && have_best_reg && cand_note > best_reg));

    assign swap_root = (best_reg == root_note) && (prior_reg == root_note) && have_second_reg;
    assign result    = !have_best_reg ? note_reg : (swap_root ? second_reg : best_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg   <= 1'b0;
            have_second_reg <= 1'b0;
        end else if (cmd.start) begin
            have_best_reg   <= 1'b0;
            have_second_reg <= 1'b0;
        end else if (cmd.step && take) begin
            have_best_reg <= 1'b1;
            if (have_best_reg) begin
                have_second_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            note_reg      <= s_input_note;
            prior_reg     <= s_prior_note;
            oct_reg       <= '0;
            idx_reg       <= '0;
            base_reg      <= CAND_W'(root_note);
            best_diff_reg <= DIFF_W'(1 << NOTE_W);
        end else if (cmd.step) begin
            if (idx_last) begin
                idx_reg  <= '0;
                oct_reg  <= oct_reg + OCT_W'(1);
                base_reg <= base_reg + CAND_W'(SEMITONES);
            end else begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (take) begin
                second_reg    <= best_reg;
                best_reg      <= cand_note;
                best_diff_reg <= diff;
            end
        end
        if (cmd.load_out) begin
            q_reg  <= result;
            fb_reg <= !have_best_reg;
        end
    end

    assign m_quantized_note = q_reg;
    assign m_fell_back      = fb_reg;

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    import scq_pkg::*;

    localparam int MAX_INTERVALS = 12;
    localparam int OCTAVE_COUNT  = 11;
    localparam int NOTE_LIMIT    = 128;
    localparam int IDLE_MAX      = 16;
    localparam int SCAN_CYCLES   = 2 + OCTAVE_COUNT * MAX_INTERVALS;

    typedef struct packed {
        logic [NOTE_W-1:0] quantized_note;
        logic              fell_back;
    } note_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [NOTE_W-1:0]     s_input_note;
    logic [NOTE_W-1:0]     s_prior_note;
    logic                  m_valid;
    logic                  m_ready;
    logic [NOTE_W-1:0]     m_quantized_note;
    logic                  m_fell_back;

    logic [NOTE_W-1:0]     scale_root;
    logic [COUNT_W-1:0]    scale_count;
    logic [TABLE_W-1:0]    scale_steps;

    note_result_t expected_notes[$];
    int error_count = 0;
    int tx_idle_max = IDLE_MAX;
    int rx_idle_max = IDLE_MAX;
    int rx_wait     = 0;
    int rx_hold     = 0;

    scale_note_quantizer #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .OCTAVE_COUNT (OCTAVE_COUNT)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_input_note    (s_input_note),
        .s_prior_note    (s_prior_note),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_quantized_note(m_quantized_note),
        .m_fell_back     (m_fell_back)
    );

    always #1 aclk = ~aclk;

    function automatic int draw_idle(int max_cycles);
        if (max_cycles == 0) begin
            return 0;
        end
        return $urandom_range(0, max_cycles);
    endfunction

    function automatic note_result_t quantize(logic [NOTE_W-1:0] note,
                                              logic [NOTE_W-1:0] prior);
        note_result_t r;
        int limit;
        int cand;
        int distance;
        int best;
        int runner_up;
        int best_distance;
        bit have_best;
        bit have_runner_up;
        limit = (scale_count > MAX_INTERVALS) ? MAX_INTERVALS : int'(scale_count);
        if (limit > TABLE_ENTRIES) begin
            limit = TABLE_ENTRIES;
        end
        have_best      = 1'b0;
        have_runner_up = 1'b0;
        best           = 0;
        runner_up      = 0;
        best_distance  = NOTE_LIMIT;
        for (int oct = 0; oct < OCTAVE_COUNT; oct++) begin
            for (int i = 0; i < limit; i++) begin
                cand = int'(scale_root) + SEMITONES * oct
                     + int'(scale_steps[STEP_W*i +: STEP_W]);
                if (cand >= NOTE_LIMIT) begin
                    continue;
                end
                distance = (cand > int'(note)) ? cand - int'(note) : int'(note) - cand;
                if (distance < best_distance
                    || (distance == best_distance && have_best && cand > best)) begin
                    if (have_best) begin
                        runner_up      = best;
                        have_runner_up = 1'b1;
                    end
                    best          = cand;
                    best_distance = distance;
                    have_best     = 1'b1;
                end
            end
        end
        if (have_best && best == int'(scale_root) && prior == scale_root && have_runner_up) begin
            best = runner_up;
        end
        r.quantized_note = have_best ? best[NOTE_W-1:0] : note;
        r.fell_back      = !have_best;
        return r;
    endfunction

    function automatic logic [NOTE_W-1:0] random_note();
        int near;
        if ($urandom_range(0, 1) == 0) begin
            near = $urandom_range(0, NOTE_LIMIT - 1);
        end else begin
            near = int'(scale_root) + int'($urandom_range(0, 40)) - 20;
            if (near < 0) begin
                near = 0;
            end
            if (near > NOTE_LIMIT - 1) begin
                near = NOTE_LIMIT - 1;
            end
        end
        return near[NOTE_W-1:0];
    endfunction

    function automatic logic [NOTE_W-1:0] random_prior();
        if ($urandom_range(0, 2) == 0) begin
            return scale_root;
        end
        return random_note();
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (index)
            CFG_ROOT_NOTE:      scale_root  = data[NOTE_W-1:0];
            CFG_INTERVAL_COUNT: scale_count = data[COUNT_W-1:0];
            CFG_INTERVAL_TABLE: scale_steps = data[TABLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_scale(logic [NOTE_W-1:0] root, logic [COUNT_W-1:0] count,
                             logic [TABLE_W-1:0] steps);
        write_reg(CFG_ROOT_NOTE, CFG_DATA_W'(root));
        write_reg(CFG_INTERVAL_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_INTERVAL_TABLE, steps);
    endtask

    task automatic send_item(logic [NOTE_W-1:0] note, logic [NOTE_W-1:0] prior);
        int gap;
        gap = draw_idle(tx_idle_max);
        repeat (gap) @(negedge aclk);
        s_valid      = 1'b1;
        s_input_note = note;
        s_prior_note = prior;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_notes.push_back(quantize(note, prior));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_notes.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic test_reset_state();
        send_item(7'd0, 7'd0);
        send_item(7'd127, 7'd127);
        send_item(7'd6, 7'd0);
        send_item(7'd125, 7'd1);
        wait_drained();
    endtask

    task automatic test_directed();
        // major scale from middle C
        set_scale(7'd60, 4'd7, 48'h0000_00B9_7542);
        set_scale(7'd60, 4'd7, 48'h0000_0B97_5420);
        send_item(7'd0, 7'd60);
        send_item(7'd60, 7'd60);
        send_item(7'd61, 7'd3);
        send_item(7'd127, 7'd127);
        wait_drained();
        // root found after another candidate, so a runner-up exists
        set_scale(7'd48, 4'd3, 48'h0000_0000_0407);
        send_item(7'd48, 7'd48);
        send_item(7'd49, 7'd48);
        send_item(7'd48, 7'd47);
        wait_drained();
        set_scale(7'd127, 4'd12, '1);
        send_item(7'd10, 7'd3);
        send_item(7'd127, 7'd127);
        wait_drained();
        set_scale(7'd33, 4'd0, 48'h1234_5678_9ABC);
        send_item(7'd45, 7'd0);
        send_item(7'd127, 7'd33);
        wait_drained();
        set_scale(7'd0, 4'd15, 48'hBA98_7654_3210);
        send_item(7'd0, 7'd0);
        send_item(7'd127, 7'd5);
        send_item(7'd77, 7'd0);
        wait_drained();
        set_scale(7'd0, 4'd12, '1);
        send_item(7'd0, 7'd0);
        send_item(7'd127, 7'd0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_scale(7'd36, 4'd1, 48'h5);
        tx_idle_max = 0;
        rx_hold     = 500;
        repeat (24) send_item(random_note(), random_prior());
        tx_idle_max = IDLE_MAX;
        wait_drained();
    endtask

    task automatic test_drain_pause();
        set_scale(7'd55, 4'd5, 48'h0000_0009_7420);
        repeat (10) send_item(random_note(), random_prior());
        wait_drained();
        repeat (10) send_item(random_note(), random_prior());
        wait_drained();
    endtask

    task automatic test_random_sweep();
        logic [NOTE_W-1:0]  root;
        logic [COUNT_W-1:0] count;
        logic [TABLE_W-1:0] steps;
        for (int phase = 0; phase < 12; phase++) begin
            root  = (phase == 1) ? 7'd0 : (phase == 2) ? 7'd127 : NOTE_W'($urandom_range(0, 127));
            count = (phase == 3) ? 4'd12 : (phase == 4) ? 4'd15 : (phase == 5) ? 4'd0
                  : COUNT_W'($urandom_range(0, 15));
            steps = (phase == 6) ? '1 : (phase == 7) ? '0
                  : {$urandom(), 16'($urandom())};
            set_scale(root, count, steps);
            tx_idle_max = (phase % 4 == 3) ? 0 : IDLE_MAX;
            rx_idle_max = (phase % 4 == 3) ? 0 : IDLE_MAX;
            for (int n = 0; n < 66; n++) begin
                if (n == 33 && phase % 4 == 1) begin
                    tx_idle_max = 0;
                    rx_idle_max = 0;
                end
                send_item(random_note(), random_prior());
            end
            tx_idle_max = IDLE_MAX;
            rx_idle_max = IDLE_MAX;
            wait_drained();
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready = 1'b0;
                rx_hold--;
            end else if (rx_wait > 0) begin
                m_ready = 1'b0;
                rx_wait--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        note_result_t want;
        if (aresetn && m_valid && m_ready) begin
            rx_wait = draw_idle(rx_idle_max);
            if (expected_notes.size() == 0) begin
                $error("unexpected item: quantized_note %0d fell_back %0d",
                       m_quantized_note, m_fell_back);
                error_count++;
            end else begin
                want = expected_notes.pop_front();
                if (m_quantized_note !== want.quantized_note) begin
                    $error("quantized_note: expected %0d, actual %0d",
                           want.quantized_note, m_quantized_note);
                    error_count++;
                end
                if (m_fell_back !== want.fell_back) begin
                    $error("fell_back: expected %0d, actual %0d", want.fell_back, m_fell_back);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_ROOT_NOTE;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_input_note = '0;
        s_prior_note = '0;
        scale_root   = '0;
        scale_count  = 4'd7;
        scale_steps  = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        test_reset_state();
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random_sweep();
        wait_drained();
        repeat (SCAN_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("scale_note_quantizer: match");
        end else begin
            $display("scale_note_quantizer: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("scale_note_quantizer: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/scq_pkg.sv
rtl/core/scq_ctrl.sv
rtl/core/scq_datapath.sv
rtl/core/scale_note_quantizer.sv
sim/tb_top.sv
